// ----- sv/spcr_pkg.sv -----
// Shared types, constants and helpers for the shape pair collide/resolve block.
`default_nettype none
package spcr_pkg;

  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_BOX    = 2'd1;
  localparam logic [1:0] KIND_CIRCLE = 2'd2;
  // unassigned code, behaves as none
  localparam logic [1:0] KIND_RSVD   = 2'd3;

  // square root: one result bit per stage; divide: one quotient bit per stage
  localparam int SQ_LAT   = 17;
  localparam int DIV_LAT  = 18;
  localparam int PIPE_LAT = SQ_LAT + DIV_LAT;

  localparam logic signed [25:0] POS_MAX = 26'sd8388607;
  localparam logic signed [25:0] POS_MIN = -26'sd8388608;

  typedef struct packed {
    logic               hit;
    logic               use_div;
    logic               neg_x;
    logic               neg_y;
    logic signed [23:0] ox;
    logic signed [23:0] oy;
    logic signed [23:0] nx;
    logic signed [23:0] ny;
  } carry_t;

  function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
    logic signed [23:0] r;
    if (v > POS_MAX) begin
      r = 24'sh7FFFFF;
    end else if (v < POS_MIN) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- sv/spcr_if.sv -----
// Valid/ready channel interfaces for shape pairs in and results out.
`default_nettype none
interface spcr_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         this_kind;
  logic signed [23:0] this_x;
  logic signed [23:0] this_y;
  logic [15:0]        this_size_a;
  logic [15:0]        this_size_b;
  logic               this_static;
  logic [1:0]         other_kind;
  logic signed [23:0] other_x;
  logic signed [23:0] other_y;
  logic [15:0]        other_size_a;
  logic [15:0]        other_size_b;

  modport source (
    output valid, this_kind, this_x, this_y, this_size_a, this_size_b, this_static,
           other_kind, other_x, other_y, other_size_a, other_size_b,
    input  ready
  );
  modport sink (
    input  valid, this_kind, this_x, this_y, this_size_a, this_size_b, this_static,
           other_kind, other_x, other_y, other_size_a, other_size_b,
    output ready
  );
endinterface

interface spcr_out_if;
  logic               valid;
  logic               ready;
  logic               colliding;
  logic signed [23:0] new_x;
  logic signed [23:0] new_y;

  modport source (output valid, colliding, new_x, new_y, input ready);
  modport sink (input valid, colliding, new_x, new_y, output ready);
endinterface
`default_nettype wire

// ----- sv/spcr_front.sv -----
// Front stages: offsets, squares and products, hit decision and box push.
`default_nettype none
module spcr_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  spcr_in_if.sink              in_i,
  output logic                 valid_o,
  output spcr_pkg::carry_t     carry_o,
  output logic [33:0]          d2_o,
  output logic [34:0]          num_x_o,
  output logic [34:0]          num_y_o
);

  // ---------------- stage 0 ----------------
  logic signed [24:0] dx0, dy0;
  logic signed [26:0] t2x, t2y, o2x, o2y;
  logic               bb0, cc0, cb0, boxhit0;
  logic [16:0]        r0, lw0, lh0, hws0, hhs0;
  logic [15:0]        rad0, bw0, bh0;

  assign in_i.ready = en_i;

  assign dx0 = $signed({in_i.other_x[23], in_i.other_x}) - $signed({in_i.this_x[23], in_i.this_x});
  assign dy0 = $signed({in_i.other_y[23], in_i.other_y}) - $signed({in_i.this_y[23], in_i.this_y});
  assign t2x = $signed({{2{in_i.this_x[23]}}, in_i.this_x, 1'b0});
  assign t2y = $signed({{2{in_i.this_y[23]}}, in_i.this_y, 1'b0});
  assign o2x = $signed({{2{in_i.other_x[23]}}, in_i.other_x, 1'b0});
  assign o2y = $signed({{2{in_i.other_y[23]}}, in_i.other_y, 1'b0});

  assign bb0 = (in_i.this_kind == spcr_pkg::KIND_BOX) && (in_i.other_kind == spcr_pkg::KIND_BOX);
  assign cc0 = (in_i.this_kind == spcr_pkg::KIND_CIRCLE) &&
               (in_i.other_kind == spcr_pkg::KIND_CIRCLE);
  assign cb0 = ((in_i.this_kind == spcr_pkg::KIND_CIRCLE) &&
                (in_i.other_kind == spcr_pkg::KIND_BOX)) ||
               ((in_i.this_kind == spcr_pkg::KIND_BOX) &&
                (in_i.other_kind == spcr_pkg::KIND_CIRCLE));

  assign boxhit0 = (t2x - $signed({11'b0, in_i.this_size_a}) <=
                    o2x + $signed({11'b0, in_i.other_size_a})) &&
                   (t2x + $signed({11'b0, in_i.this_size_a}) >=
                    o2x - $signed({11'b0, in_i.other_size_a})) &&
                   (t2y - $signed({11'b0, in_i.this_size_b}) <=
                    o2y + $signed({11'b0, in_i.other_size_b})) &&
                   (t2y + $signed({11'b0, in_i.this_size_b}) >=
                    o2y - $signed({11'b0, in_i.other_size_b}));

  assign r0   = {1'b0, in_i.this_size_a} + {1'b0, in_i.other_size_a};
  assign rad0 = (in_i.this_kind == spcr_pkg::KIND_CIRCLE) ? in_i.this_size_a : in_i.other_size_a;
  assign bw0  = (in_i.this_kind == spcr_pkg::KIND_BOX) ? in_i.this_size_a : in_i.other_size_a;
  assign bh0  = (in_i.this_kind == spcr_pkg::KIND_BOX) ? in_i.this_size_b : in_i.other_size_b;
  assign lw0  = {1'b0, bw0} + {1'b0, rad0};
  assign lh0  = {1'b0, bh0} + {1'b0, rad0};
  assign hws0 = r0 + 17'd1;
  assign hhs0 = {1'b0, in_i.this_size_b} + {1'b0, in_i.other_size_b} + 17'd1;

  logic               s0_v_q;
  logic               s0_bb_q, s0_cc_q, s0_cb_q, s0_stat_q, s0_boxhit_q;
  logic signed [23:0] s0_tx_q, s0_ty_q, s0_ox_q, s0_oy_q;
  logic signed [24:0] s0_dx_q, s0_dy_q;
  logic [16:0]        s0_r_q, s0_lw_q, s0_lh_q;
  logic [15:0]        s0_bw_q, s0_bh_q, s0_hw_q, s0_hh_q;

  // ---------------- stage 1 ----------------
  logic [24:0]        ax1, ay1;
  logic [49:0]        dx2_1, dy2_1;
  logic [33:0]        r2_1, lw2_1, lh2_1, ax_r1, ay_r1;
  logic [31:0]        bw2_1, bh2_1;
  logic signed [25:0] ox26, oy26, hw26, hh26;
  logic signed [23:0] bnx1, bny1, coin1;

  assign ax1   = s0_dx_q[24] ? 25'(-s0_dx_q) : 25'(s0_dx_q);
  assign ay1   = s0_dy_q[24] ? 25'(-s0_dy_q) : 25'(s0_dy_q);
  assign dx2_1 = ax1 * ax1;
  assign dy2_1 = ay1 * ay1;
  assign r2_1  = s0_r_q * s0_r_q;
  assign lw2_1 = s0_lw_q * s0_lw_q;
  assign lh2_1 = s0_lh_q * s0_lh_q;
  assign bw2_1 = s0_bw_q * s0_bw_q;
  assign bh2_1 = s0_bh_q * s0_bh_q;
  // on a circle hit both offsets are below the radius sum, so 17 bits suffice
  assign ax_r1 = ax1[16:0] * s0_r_q;
  assign ay_r1 = ay1[16:0] * s0_r_q;

  assign ox26 = $signed({{2{s0_ox_q[23]}}, s0_ox_q});
  assign oy26 = $signed({{2{s0_oy_q[23]}}, s0_oy_q});
  assign hw26 = $signed({10'b0, s0_hw_q});
  assign hh26 = $signed({10'b0, s0_hh_q});

  always_comb begin
    bnx1 = s0_tx_q;
    bny1 = s0_ty_q;
    if (ax1 > ay1) begin
      bnx1 = (s0_dx_q > 25'sd0) ? spcr_pkg::sat24(ox26 - hw26) : spcr_pkg::sat24(ox26 + hw26);
    end else if (ay1 > ax1) begin
      bny1 = (s0_dy_q > 25'sd0) ? spcr_pkg::sat24(oy26 - hh26) : spcr_pkg::sat24(oy26 + hh26);
    end
  end

  // coincident centres push along minus x
  assign coin1 = spcr_pkg::sat24($signed({{2{s0_tx_q[23]}}, s0_tx_q}) - $signed({9'b0, s0_r_q}));

  logic               s1_v_q;
  logic               s1_bb_q, s1_cc_q, s1_cb_q, s1_stat_q, s1_boxhit_q;
  logic               s1_negx_q, s1_negy_q;
  logic [49:0]        s1_dx2_q, s1_dy2_q;
  logic [33:0]        s1_r2_q, s1_lw2_q, s1_lh2_q;
  logic [31:0]        s1_bw2_q, s1_bh2_q;
  logic [34:0]        s1_numx_q, s1_numy_q;
  logic signed [23:0] s1_bnx_q, s1_bny_q, s1_coin_q, s1_tx_q, s1_ty_q, s1_ox_q, s1_oy_q;

  // ---------------- stage 2 ----------------
  logic [50:0]      d2_2;
  logic             hit2, mv2;
  spcr_pkg::carry_t carry2;

  assign d2_2 = {1'b0, s1_dx2_q} + {1'b0, s1_dy2_q};

  always_comb begin
    if (s1_bb_q) begin
      hit2 = s1_boxhit_q;
    end else if (s1_cc_q) begin
      hit2 = d2_2 < {17'b0, s1_r2_q};
    end else if (s1_cb_q) begin
      hit2 = !((d2_2 > {17'b0, s1_lw2_q}) || (d2_2 > {17'b0, s1_lh2_q})) &&
             ((d2_2 <= {19'b0, s1_bw2_q}) || (d2_2 <= {19'b0, s1_bh2_q}));
    end else begin
      hit2 = 1'b0;
    end
    mv2 = hit2 && !s1_stat_q;

    carry2.hit     = hit2;
    carry2.use_div = mv2 && s1_cc_q && (d2_2 != '0);
    carry2.neg_x   = s1_negx_q;
    carry2.neg_y   = s1_negy_q;
    carry2.ox      = s1_ox_q;
    carry2.oy      = s1_oy_q;
    carry2.nx      = s1_tx_q;
    carry2.ny      = s1_ty_q;
    if (mv2 && s1_bb_q) begin
      carry2.nx = s1_bnx_q;
      carry2.ny = s1_bny_q;
    end else if (mv2 && s1_cc_q && (d2_2 == '0)) begin
      carry2.nx = s1_coin_q;
    end
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q  <= 1'b0;
      s1_v_q  <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      s0_v_q  <= in_i.valid;
      s1_v_q  <= s0_v_q;
      valid_o <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s0_bb_q     <= bb0;
      s0_cc_q     <= cc0;
      s0_cb_q     <= cb0;
      s0_stat_q   <= in_i.this_static;
      s0_boxhit_q <= boxhit0;
      s0_tx_q     <= in_i.this_x;
      s0_ty_q     <= in_i.this_y;
      s0_ox_q     <= in_i.other_x;
      s0_oy_q     <= in_i.other_y;
      s0_dx_q     <= dx0;
      s0_dy_q     <= dy0;
      s0_r_q      <= r0;
      s0_lw_q     <= lw0;
      s0_lh_q     <= lh0;
      s0_bw_q     <= bw0;
      s0_bh_q     <= bh0;
      s0_hw_q     <= hws0[16:1];
      s0_hh_q     <= hhs0[16:1];

      s1_bb_q     <= s0_bb_q;
      s1_cc_q     <= s0_cc_q;
      s1_cb_q     <= s0_cb_q;
      s1_stat_q   <= s0_stat_q;
      s1_boxhit_q <= s0_boxhit_q;
      s1_negx_q   <= s0_dx_q[24];
      s1_negy_q   <= s0_dy_q[24];
      s1_dx2_q    <= dx2_1;
      s1_dy2_q    <= dy2_1;
      s1_r2_q     <= r2_1;
      s1_lw2_q    <= lw2_1;
      s1_lh2_q    <= lh2_1;
      s1_bw2_q    <= bw2_1;
      s1_bh2_q    <= bh2_1;
      s1_numx_q   <= {ax_r1, 1'b0};
      s1_numy_q   <= {ay_r1, 1'b0};
      s1_bnx_q    <= bnx1;
      s1_bny_q    <= bny1;
      s1_coin_q   <= coin1;
      s1_tx_q     <= s0_tx_q;
      s1_ty_q     <= s0_ty_q;
      s1_ox_q     <= s0_ox_q;
      s1_oy_q     <= s0_oy_q;

      carry_o     <= carry2;
      d2_o        <= d2_2[33:0];
      num_x_o     <= s1_numx_q;
      num_y_o     <= s1_numy_q;
    end
  end

endmodule
`default_nettype wire

// ----- sv/spcr_sqrt.sv -----
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module spcr_sqrt (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [33:0] d_i,
  output logic [16:0]      root_o
);

  logic [33:0] d_q    [spcr_pkg::SQ_LAT];
  logic [18:0] rem_q  [spcr_pkg::SQ_LAT];
  logic [16:0] root_q [spcr_pkg::SQ_LAT];

  for (genvar i = 0; i < spcr_pkg::SQ_LAT; i++) begin : g_stage
    logic [33:0] d_in;
    logic [18:0] rem_in;
    logic [16:0] root_in;
    logic [20:0] cur, trial;
    logic [18:0] rem_d;
    logic [16:0] root_d;

    if (i == 0) begin : g_first
      assign d_in    = d_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign d_in    = d_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
    end

    assign cur   = {rem_in, d_in[33-2*i -: 2]};
    assign trial = {2'b0, root_in, 2'b01};

    always_comb begin
      if (cur >= trial) begin
        rem_d  = 19'(cur - trial);
        root_d = {root_in[15:0], 1'b1};
      end else begin
        rem_d  = cur[18:0];
        root_d = {root_in[15:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d_q[i]    <= d_in;
        rem_q[i]  <= rem_d;
        root_q[i] <= root_d;
      end
    end
  end

  assign root_o = root_q[spcr_pkg::SQ_LAT-1];

endmodule
`default_nettype wire

// ----- sv/spcr_div.sv -----
// Pipelined restoring divider, one quotient bit per stage (quotient below 2^18).
`default_nettype none
module spcr_div (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [35:0] n_i,
  input  wire logic [17:0] d_i,
  output logic [17:0]      q_o
);

  logic [35:0] n_q   [spcr_pkg::DIV_LAT];
  logic [17:0] d_q   [spcr_pkg::DIV_LAT];
  logic [17:0] rem_q [spcr_pkg::DIV_LAT];
  logic [17:0] q_q   [spcr_pkg::DIV_LAT];

  for (genvar j = 0; j < spcr_pkg::DIV_LAT; j++) begin : g_stage
    logic [35:0] n_in;
    logic [17:0] d_in, rem_in, q_in, rem_d, q_d;
    logic [18:0] cur;

    if (j == 0) begin : g_first
      // upper half seeds the remainder; it is below the divisor
      assign n_in   = n_i;
      assign d_in   = d_i;
      assign rem_in = n_i[35:18];
      assign q_in   = '0;
    end else begin : g_next
      assign n_in   = n_q[j-1];
      assign d_in   = d_q[j-1];
      assign rem_in = rem_q[j-1];
      assign q_in   = q_q[j-1];
    end

    assign cur = {rem_in, n_in[17-j]};

    always_comb begin
      if (cur >= {1'b0, d_in}) begin
        rem_d = 18'(cur - {1'b0, d_in});
        q_d   = {q_in[16:0], 1'b1};
      end else begin
        rem_d = cur[17:0];
        q_d   = {q_in[16:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[j]   <= n_in;
        d_q[j]   <= d_in;
        rem_q[j] <= rem_d;
        q_q[j]   <= q_d;
      end
    end
  end

  assign q_o = q_q[spcr_pkg::DIV_LAT-1];

endmodule
`default_nettype wire

// ----- sv/shape_pair_collide_resolve_top.sv -----
// Top level: shape pair collision test and push-out pipeline with output skid.
//
// Takes one shape pair per cycle while the skid is empty and returns one
// result per pair, in order. Each pair passes through three front stages
// (offsets, squares and products, hit decision), a 17-stage square root of
// the squared centre distance, an 18-stage divider for the circle push
// scale, and an output register. The square root and divider resolve one
// bit per stage. A skid register behind the output keeps one result when
// the sink stalls; the whole pipeline holds while the skid is full.
`default_nettype none
module shape_pair_collide_resolve_top (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  spcr_in_if.sink     in_i,
  spcr_out_if.source  out_o
);

  logic             en;
  logic             fr_valid;
  spcr_pkg::carry_t fr_carry;
  logic [33:0]      fr_d2;
  logic [34:0]      fr_numx, fr_numy;

  logic             skid_full_q;

  assign en = !skid_full_q;

  spcr_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .in_i    (in_i),
    .valid_o (fr_valid),
    .carry_o (fr_carry),
    .d2_o    (fr_d2),
    .num_x_o (fr_numx),
    .num_y_o (fr_numy)
  );

  logic [16:0] root;

  spcr_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .d_i    (fr_d2),
    .root_o (root)
  );

  // side payload travels alongside the root and divide stages
  logic             valid_q [spcr_pkg::PIPE_LAT];
  spcr_pkg::carry_t carry_q [spcr_pkg::PIPE_LAT];
  logic [34:0]      numx_q  [spcr_pkg::SQ_LAT];
  logic [34:0]      numy_q  [spcr_pkg::SQ_LAT];

  logic [35:0] nx_num, ny_num;
  logic [17:0] den, qx, qy;

  assign nx_num = {1'b0, numx_q[spcr_pkg::SQ_LAT-1]} + {19'b0, root};
  assign ny_num = {1'b0, numy_q[spcr_pkg::SQ_LAT-1]} + {19'b0, root};
  assign den    = {root, 1'b0};

  spcr_div u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .n_i   (nx_num),
    .d_i   (den),
    .q_o   (qx)
  );

  spcr_div u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .n_i   (ny_num),
    .d_i   (den),
    .q_o   (qy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < spcr_pkg::PIPE_LAT; k++) begin
        valid_q[k] <= 1'b0;
      end
    end else if (en) begin
      valid_q[0] <= fr_valid;
      for (int k = 1; k < spcr_pkg::PIPE_LAT; k++) begin
        valid_q[k] <= valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      carry_q[0] <= fr_carry;
      numx_q[0]  <= fr_numx;
      numy_q[0]  <= fr_numy;
      for (int k = 1; k < spcr_pkg::PIPE_LAT; k++) begin
        carry_q[k] <= carry_q[k-1];
      end
      for (int k = 1; k < spcr_pkg::SQ_LAT; k++) begin
        numx_q[k] <= numx_q[k-1];
        numy_q[k] <= numy_q[k-1];
      end
    end
  end

  // final stage: apply signed circle push and saturate, or pass the front result
  spcr_pkg::carry_t   c_last;
  logic signed [25:0] ox26, oy26, qx26, qy26;
  logic signed [23:0] fin_x_d, fin_y_d;

  assign c_last = carry_q[spcr_pkg::PIPE_LAT-1];
  assign ox26   = $signed({{2{c_last.ox[23]}}, c_last.ox});
  assign oy26   = $signed({{2{c_last.oy[23]}}, c_last.oy});
  assign qx26   = $signed({8'b0, qx});
  assign qy26   = $signed({8'b0, qy});

  always_comb begin
    if (c_last.use_div) begin
      fin_x_d = c_last.neg_x ? spcr_pkg::sat24(ox26 + qx26) : spcr_pkg::sat24(ox26 - qx26);
      fin_y_d = c_last.neg_y ? spcr_pkg::sat24(oy26 + qy26) : spcr_pkg::sat24(oy26 - qy26);
    end else begin
      fin_x_d = c_last.nx;
      fin_y_d = c_last.ny;
    end
  end

  logic               fin_valid_q, fin_hit_q;
  logic signed [23:0] fin_x_q, fin_y_q;
  logic               skid_hit_q;
  logic signed [23:0] skid_x_q, skid_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
      skid_full_q <= 1'b0;
    end else begin
      if (en) begin
        fin_valid_q <= valid_q[spcr_pkg::PIPE_LAT-1];
      end
      if (skid_full_q && out_o.ready) begin
        skid_full_q <= 1'b0;
      end else if (en && fin_valid_q && !out_o.ready) begin
        skid_full_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fin_hit_q <= c_last.hit;
      fin_x_q   <= fin_x_d;
      fin_y_q   <= fin_y_d;
    end
    if (en && fin_valid_q && !out_o.ready) begin
      skid_hit_q <= fin_hit_q;
      skid_x_q   <= fin_x_q;
      skid_y_q   <= fin_y_q;
    end
  end

  assign out_o.valid     = skid_full_q || fin_valid_q;
  assign out_o.colliding = skid_full_q ? skid_hit_q : fin_hit_q;
  assign out_o.new_x     = skid_full_q ? skid_x_q : fin_x_q;
  assign out_o.new_y     = skid_full_q ? skid_y_q : fin_y_q;

endmodule
`default_nettype wire

// ----- bench/tb_spcr_checker.sv -----
// Collision result checker: predicts every accepted shape pair and compares results.
module tb_spcr_checker (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  spcr_in_if        in_i,
  spcr_out_if       out_o,
  output int        fail_cnt_o,
  output int        pending_o
);

  typedef struct {
    logic               colliding;
    logic signed [23:0] new_x;
    logic signed [23:0] new_y;
  } result_t;

  result_t expected_q[$];

  function automatic longint clamp_pos(input longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  function automatic longint int_sqrt(input longint n);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  // half away from zero
  function automatic longint round_div(input longint num, input longint den);
    longint a, q;
    a = (num < 0) ? -num : num;
    q = (2 * a + den) / (2 * den);
    return (num < 0) ? -q : q;
  endfunction

  function automatic result_t predict_push(
    input logic [1:0] tk, input longint tx, input longint ty, input longint ta,
    input longint tb, input logic tstat, input logic [1:0] ok, input longint ox,
    input longint oy, input longint oa, input longint ob);
    result_t res;
    longint dx, dy, d2, nx, ny, r, rad, bw, bh, lw, lh, hw, hh, ax, ay, cdist;
    logic hit;
    dx = ox - tx;
    dy = oy - ty;
    d2 = dx * dx + dy * dy;
    hit = 1'b0;
    nx = tx;
    ny = ty;
    if (tk == spcr_pkg::KIND_BOX && ok == spcr_pkg::KIND_BOX) begin
      hit = (2*tx - ta <= 2*ox + oa) && (2*tx + ta >= 2*ox - oa) &&
            (2*ty - tb <= 2*oy + ob) && (2*ty + tb >= 2*oy - ob);
    end else if (tk == spcr_pkg::KIND_CIRCLE && ok == spcr_pkg::KIND_CIRCLE) begin
      r = ta + oa;
      hit = d2 < r * r;
    end else if ((tk == spcr_pkg::KIND_CIRCLE && ok == spcr_pkg::KIND_BOX) ||
                 (tk == spcr_pkg::KIND_BOX && ok == spcr_pkg::KIND_CIRCLE)) begin
      rad = (tk == spcr_pkg::KIND_CIRCLE) ? ta : oa;
      bw = (tk == spcr_pkg::KIND_BOX) ? ta : oa;
      bh = (tk == spcr_pkg::KIND_BOX) ? tb : ob;
      lw = bw + rad;
      lh = bh + rad;
      if (d2 > lw * lw || d2 > lh * lh) hit = 1'b0;
      else hit = (d2 <= bw * bw) || (d2 <= bh * bh);
    end
    if (hit && !tstat) begin
      if (tk == spcr_pkg::KIND_BOX && ok == spcr_pkg::KIND_BOX) begin
        hw = (ta + oa + 1) >>> 1;
        hh = (tb + ob + 1) >>> 1;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        if (ax > ay) nx = (tx < ox) ? ox - hw : ox + hw;
        else if (ay > ax) ny = (ty < oy) ? oy - hh : oy + hh;
      end else if (tk == spcr_pkg::KIND_CIRCLE && ok == spcr_pkg::KIND_CIRCLE) begin
        r = ta + oa;
        if (d2 == 0) begin
          nx = tx - r;
        end else begin
          cdist = int_sqrt(d2);
          nx = ox - round_div(dx * r, cdist);
          ny = oy - round_div(dy * r, cdist);
        end
      end
    end
    res.colliding = hit;
    res.new_x = 24'(clamp_pos(nx));
    res.new_y = 24'(clamp_pos(ny));
    return res;
  endfunction

  initial begin
    fail_cnt_o = 0;
    pending_o = 0;
  end

  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && in_i.valid && in_i.ready) begin
      expected_q.push_back(predict_push(in_i.this_kind, in_i.this_x, in_i.this_y,
        in_i.this_size_a, in_i.this_size_b, in_i.this_static, in_i.other_kind,
        in_i.other_x, in_i.other_y, in_i.other_size_a, in_i.other_size_b));
    end
    if (rst_ni && out_o.valid && out_o.ready) begin
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected");
        fail_cnt_o++;
      end else begin
        e = expected_q.pop_front();
        if (out_o.colliding !== e.colliding) begin
          $error("colliding: expected %0d actual %0d", e.colliding, out_o.colliding);
          fail_cnt_o++;
        end
        if (out_o.new_x !== e.new_x) begin
          $error("new_x: expected %0d actual %0d", e.new_x, out_o.new_x);
          fail_cnt_o++;
        end
        if (out_o.new_y !== e.new_y) begin
          $error("new_y: expected %0d actual %0d", e.new_y, out_o.new_y);
          fail_cnt_o++;
        end
      end
    end
    pending_o = expected_q.size();
  end
endmodule

// ----- bench/tb_top.sv -----
// Testbench top: shape pair stimulus, sink stalls and the verdict.
module tb_top;

  localparam int NUM_RANDOM = 1150;
  localparam int IDLE_LIMIT = 5000;

  logic clk_i;
  logic rst_ni;
  int   fail_cnt;
  int   pending;
  int   idle_cycles;
  bit   stim_done;
  bit   long_hold;

  spcr_in_if  in_ch();
  spcr_out_if out_ch();

  shape_pair_collide_resolve_top u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  tb_spcr_checker u_chk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_ch),
    .out_o     (out_ch),
    .fail_cnt_o(fail_cnt),
    .pending_o (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.this_kind = '0;
    in_ch.this_x = '0;
    in_ch.this_y = '0;
    in_ch.this_size_a = '0;
    in_ch.this_size_b = '0;
    in_ch.this_static = 1'b0;
    in_ch.other_kind = '0;
    in_ch.other_x = '0;
    in_ch.other_y = '0;
    in_ch.other_size_a = '0;
    in_ch.other_size_b = '0;
    out_ch.ready = 1'b0;
  end

  // drive one pair and hold it until the block takes the beat
  task automatic send_pair(input logic [1:0] tk, input logic [23:0] tx, input logic [23:0] ty,
                           input logic [15:0] ta, input logic [15:0] tb, input logic ts,
                           input logic [1:0] ok, input logic [23:0] ox, input logic [23:0] oy,
                           input logic [15:0] oa, input logic [15:0] ob);
    in_ch.valid <= 1'b1;
    in_ch.this_kind <= tk;
    in_ch.this_x <= tx;
    in_ch.this_y <= ty;
    in_ch.this_size_a <= ta;
    in_ch.this_size_b <= tb;
    in_ch.this_static <= ts;
    in_ch.other_kind <= ok;
    in_ch.other_x <= ox;
    in_ch.other_y <= oy;
    in_ch.other_size_a <= oa;
    in_ch.other_size_b <= ob;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic idle_gap(input int n);
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  function automatic logic [23:0] rand_pos();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom_range(1) ? 24'h7FFFFF - $urandom_range(3000)
                                  : 24'h800000 + $urandom_range(3000);
      default: return 24'($signed($urandom_range(8000)) - 4000);
    endcase
  endfunction

  function automatic logic [15:0] rand_size();
    return $urandom_range(1) ? 16'($urandom()) : 16'($urandom_range(3000));
  endfunction

  function automatic logic [1:0] rand_kind();
    int k;
    k = $urandom_range(19);
    if (k < 8) return spcr_pkg::KIND_BOX;
    if (k < 16) return spcr_pkg::KIND_CIRCLE;
    return (k < 18) ? spcr_pkg::KIND_NONE : spcr_pkg::KIND_RSVD;
  endfunction

  initial begin
    logic [23:0] tx, ty;
    int burst;
    rst_ni = 1'b0;
    stim_done = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: box/circle pairs, box axis ties, coincident circles, saturation
    send_pair(spcr_pkg::KIND_BOX, 0, 0, 512, 512, 0,
              spcr_pkg::KIND_BOX, 100, 10, 512, 512);
    send_pair(spcr_pkg::KIND_BOX, 0, 0, 512, 512, 0,
              spcr_pkg::KIND_BOX, 10, -100, 512, 256);
    send_pair(spcr_pkg::KIND_BOX, 0, 0, 512, 512, 0,
              spcr_pkg::KIND_BOX, 50, 50, 512, 512);
    send_pair(spcr_pkg::KIND_BOX, 0, 0, 512, 512, 1,
              spcr_pkg::KIND_BOX, 100, 10, 512, 512);
    send_pair(spcr_pkg::KIND_BOX, 0, 0, 10, 10, 0,
              spcr_pkg::KIND_BOX, 5000, 0, 10, 10);
    send_pair(spcr_pkg::KIND_CIRCLE, 0, 0, 300, 0, 0,
              spcr_pkg::KIND_CIRCLE, 200, 100, 300, 0);
    send_pair(spcr_pkg::KIND_CIRCLE, 77, -5, 300, 0, 0,
              spcr_pkg::KIND_CIRCLE, 77, -5, 300, 0);
    send_pair(spcr_pkg::KIND_CIRCLE, 0, 0, 300, 0, 1,
              spcr_pkg::KIND_CIRCLE, 0, 1, 300, 0);
    send_pair(spcr_pkg::KIND_CIRCLE, 0, 0, 10, 0, 0,
              spcr_pkg::KIND_CIRCLE, 20, 0, 10, 0);
    send_pair(spcr_pkg::KIND_CIRCLE, 0, 0, 100, 0, 0,
              spcr_pkg::KIND_BOX, 50, 50, 400, 400);
    send_pair(spcr_pkg::KIND_BOX, 0, 0, 400, 30, 0,
              spcr_pkg::KIND_CIRCLE, 300, 0, 100, 0);
    send_pair(spcr_pkg::KIND_BOX, 0, 0, 400, 400, 0,
              spcr_pkg::KIND_NONE, 0, 0, 400, 400);
    send_pair(spcr_pkg::KIND_RSVD, 0, 0, 400, 400, 0,
              spcr_pkg::KIND_BOX, 0, 0, 400, 400);
    send_pair(spcr_pkg::KIND_CIRCLE, 24'h7FFFFF, 0, 16'hFFFF, 0, 0,
              spcr_pkg::KIND_CIRCLE, 24'h7FFF00, 0, 16'hFFFF, 0);
    send_pair(spcr_pkg::KIND_CIRCLE, 24'h800000, 24'h800000, 16'hFFFF, 16'hFFFF, 0,
              spcr_pkg::KIND_CIRCLE, 24'h800100, 24'h800080, 16'hFFFF, 16'hFFFF);
    send_pair(spcr_pkg::KIND_BOX, 24'h7FFFFF, 24'h7FFFFF, 16'hFFFF, 16'hFFFF, 0,
              spcr_pkg::KIND_BOX, 24'h7FFFF0, 24'h7FFF00, 16'hFFFF, 16'hFFFF);
    send_pair(spcr_pkg::KIND_BOX, 24'h800000, 24'h800000, 16'hFFFF, 16'hFFFF, 0,
              spcr_pkg::KIND_BOX, 24'h800100, 24'h800010, 16'hFFFF, 16'hFFFF);
    send_pair(spcr_pkg::KIND_BOX, 24'h7FFFFF, 24'h800000, 0, 0, 1,
              spcr_pkg::KIND_CIRCLE, 24'h800000, 24'h7FFFFF, 0, 0);
    // random: mostly near pairs so collisions and push-outs dominate
    for (int i = 0; i < NUM_RANDOM; ) begin
      burst = $urandom_range(30, 1);
      for (int j = 0; j < burst && i < NUM_RANDOM; j++, i++) begin
        tx = rand_pos();
        ty = rand_pos();
        if ($urandom_range(9) < 8)
          send_pair(rand_kind(), tx, ty, rand_size(), rand_size(), $urandom_range(5) == 0,
                    rand_kind(), tx + 24'($signed($urandom_range(4000)) - 2000),
                    ty + 24'($signed($urandom_range(4000)) - 2000), rand_size(), rand_size());
        else
          send_pair(rand_kind(), tx, ty, rand_size(), rand_size(), $urandom_range(1),
                    rand_kind(), rand_pos(), rand_pos(), rand_size(), rand_size());
      end
      idle_gap($urandom_range(3) == 0 ? 0 : $urandom_range(6));
    end
    in_ch.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // sink stall pattern, with one long hold-off to fill the pipeline
  initial begin
    int k;
    long_hold = 1'b0;
    @(posedge rst_ni);
    for (k = 0; ; k++) begin
      @(posedge clk_i);
      if (k == 300) begin
        long_hold = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (150) @(posedge clk_i);
        long_hold = 1'b0;
      end
      if ((k / 200) % 2 == 0) out_ch.ready <= 1'b1;
      else out_ch.ready <= ($urandom_range(3) != 0);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (rst_ni === 1'b1);
    fork
      begin
        wait (stim_done && pending == 0);
        repeat (60) @(posedge clk_i);
        if (fail_cnt == 0) $display("tb: success");
        else $display("tb: failure");
      end
      begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("tb: failure");
      end
    join_any
    $finish;
  end
endmodule
